/* rtl/ppi_pkg.sv */
`timescale 1ns / 1ps

package ppi_pkg;

    localparam int TABLE_ENTRIES = 1024;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = IDX_W + 1;
    localparam int ADDR_W        = IDX_W + 1;
    localparam int MEM_DEPTH     = 2 * TABLE_ENTRIES;
    localparam int DOC_W         = 16;
    localparam int POS_W         = 20;
    localparam int GAP_W         = 8;
    localparam int WORD_W        = DOC_W + POS_W;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_LOAD   = 2'd1,
        CMD_PROBE  = 2'd2,
        CMD_COMMIT = 2'd3
    } cmd_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    typedef struct packed {
        cmd_t              cmd;
        logic [DOC_W-1:0]  doc_id;
        logic [POS_W-1:0]  word_pos;
        logic [GAP_W-1:0]  gap;
    } item_t;

    typedef struct packed {
        logic              overflow;
        logic [CNT_W-1:0]  doc_count;
        logic [CNT_W-1:0]  entry_count;
        logic [POS_W-1:0]  match_pos;
        logic [DOC_W-1:0]  match_doc;
        logic              matched;
    } result_t;

endpackage

/* rtl/ppi_mem.sv */
`timescale 1ns / 1ps

module ppi_mem (
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [ppi_pkg::ADDR_W-1:0]  wr_addr,
    input  logic [ppi_pkg::WORD_W-1:0]  wr_data,
    input  logic [ppi_pkg::ADDR_W-1:0]  rd_addr,
    output logic [ppi_pkg::WORD_W-1:0]  rd_data
);
    import ppi_pkg::*;

    logic [WORD_W-1:0] mem [MEM_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

/* rtl/ppi_engine.sv */
`timescale 1ns / 1ps

module ppi_engine (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    input  ppi_pkg::item_t              item,
    output logic                        item_ready,
    input  logic                        out_free,
    output logic                        res_valid,
    output ppi_pkg::result_t            res,
    output logic                        wr_en,
    output logic [ppi_pkg::ADDR_W-1:0]  wr_addr,
    output logic [ppi_pkg::WORD_W-1:0]  wr_data,
    output logic [ppi_pkg::ADDR_W-1:0]  rd_addr,
    input  logic [ppi_pkg::WORD_W-1:0]  rd_data
);
    import ppi_pkg::*;

    localparam logic [CNT_W-1:0] FULL   = CNT_W'(TABLE_ENTRIES);
    localparam logic [DOC_W:0]   NO_DOC = '1;

    state_t            state_reg, state_next;
    item_t             item_reg, item_next;
    logic              bank_reg, bank_next;
    logic [CNT_W-1:0]  cur_cnt_reg, cur_cnt_next;
    logic [CNT_W-1:0]  nxt_cnt_reg, nxt_cnt_next;
    logic [CNT_W-1:0]  mp_reg, mp_next;
    logic [CNT_W-1:0]  ndoc_reg, ndoc_next;
    logic [DOC_W:0]    last_doc_reg, last_doc_next;

    logic [DOC_W-1:0]  rd_doc;
    logic [POS_W-1:0]  rd_pos;
    logic [POS_W-1:0]  target;
    logic              pos_ok;
    logic              in_range;
    logic              key_less;
    logic              key_eq;
    logic              scan_step;

    assign rd_doc   = rd_data[WORD_W-1:POS_W];
    assign rd_pos   = rd_data[POS_W-1:0];
    assign pos_ok   = item_reg.word_pos >= POS_W'(item_reg.gap);
    assign target   = item_reg.word_pos - POS_W'(item_reg.gap);
    assign in_range = mp_reg < cur_cnt_reg;
    assign key_less = (rd_doc < item_reg.doc_id)
                   || (rd_doc == item_reg.doc_id && rd_pos < target);
    assign key_eq   = rd_doc == item_reg.doc_id && rd_pos == target;
    assign scan_step = item_reg.cmd == CMD_PROBE && pos_ok && in_range && key_less;

    // The read port always fetches the entry under the next merge pointer, so
    // the data for the pointer is ready in the cycle after it settles.
    assign rd_addr = {bank_next, mp_next[IDX_W-1:0]};

    always_comb
    begin
        state_next    = state_reg;
        item_next     = item_reg;
        bank_next     = bank_reg;
        cur_cnt_next  = cur_cnt_reg;
        nxt_cnt_next  = nxt_cnt_reg;
        mp_next       = mp_reg;
        ndoc_next     = ndoc_reg;
        last_doc_next = last_doc_reg;
        item_ready    = 1'b0;
        res_valid     = 1'b0;
        res           = '0;
        wr_en         = 1'b0;
        wr_addr       = {~bank_reg, nxt_cnt_reg[IDX_W-1:0]};
        wr_data       = {item_reg.doc_id, item_reg.word_pos};

        case (state_reg)
            ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    item_next  = item;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (scan_step)
                begin
                    mp_next = mp_reg + 1'b1;
                end
                else if (out_free)
                begin
                    res_valid  = 1'b1;
                    state_next = ST_IDLE;
                    case (item_reg.cmd)
                        CMD_CLEAR:
                        begin
                            cur_cnt_next  = '0;
                            nxt_cnt_next  = '0;
                            mp_next       = '0;
                            ndoc_next     = '0;
                            last_doc_next = NO_DOC;
                        end
                        CMD_LOAD:
                        begin
                            if (cur_cnt_reg < FULL)
                            begin
                                wr_en        = 1'b1;
                                wr_addr      = {bank_reg, cur_cnt_reg[IDX_W-1:0]};
                                cur_cnt_next = cur_cnt_reg + 1'b1;
                            end
                            else
                            begin
                                res.overflow = 1'b1;
                            end
                        end
                        CMD_PROBE:
                        begin
                            if (pos_ok && in_range && key_eq)
                            begin
                                mp_next       = mp_reg + 1'b1;
                                res.matched   = 1'b1;
                                res.match_doc = item_reg.doc_id;
                                res.match_pos = item_reg.word_pos;
                                if (nxt_cnt_reg < FULL)
                                begin
                                    wr_en        = 1'b1;
                                    nxt_cnt_next = nxt_cnt_reg + 1'b1;
                                    if ({1'b0, item_reg.doc_id} != last_doc_reg)
                                    begin
                                        ndoc_next     = ndoc_reg + 1'b1;
                                        last_doc_next = {1'b0, item_reg.doc_id};
                                    end
                                end
                                else
                                begin
                                    res.overflow = 1'b1;
                                end
                            end
                        end
                        CMD_COMMIT:
                        begin
                            bank_next       = ~bank_reg;
                            cur_cnt_next    = nxt_cnt_reg;
                            res.entry_count = nxt_cnt_reg;
                            res.doc_count   = ndoc_reg;
                            nxt_cnt_next    = '0;
                            mp_next         = '0;
                            ndoc_next       = '0;
                            last_doc_next   = NO_DOC;
                        end
                        default:
                        begin
                            res_valid = 1'b1;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            bank_reg     <= 1'b0;
            cur_cnt_reg  <= '0;
            nxt_cnt_reg  <= '0;
            mp_reg       <= '0;
            ndoc_reg     <= '0;
            last_doc_reg <= NO_DOC;
        end
        else
        begin
            state_reg    <= state_next;
            bank_reg     <= bank_next;
            cur_cnt_reg  <= cur_cnt_next;
            nxt_cnt_reg  <= nxt_cnt_next;
            mp_reg       <= mp_next;
            ndoc_reg     <= ndoc_next;
            last_doc_reg <= last_doc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

endmodule

/* rtl/positional_phrase_intersect.sv */
`timescale 1ns / 1ps
// Phrase-match extension over a positional index, kept in a two-bank entry memory.
// Input stream (s_*): one request per handshake. s_tuser carries the command
// (clear, load into the current bank, probe with the next term, commit).
// s_tdata carries document, word position and gap of the request.
// Output stream (m_*): exactly one result per request, in request order.
// A probe walks a merge pointer through the sorted current bank, one stored
// entry per cycle on the memory's read port; a match is appended to the other
// bank. A commit swaps the banks and reports entry and document counts.
// Sequencing: a request is accepted in the idle state and executed in the
// exec state; its result enters the result register when that is free, and
// the next request is taken once the block is back in idle. A probe first
// stays in exec while the merge pointer passes stored entries. The registered
// memory read sets the one-entry-per-cycle scan.
// The result register decouples the sides: a new request is accepted while a
// result is still waiting, but the next result is held back until m_tready
// frees the register. Nothing is lost when the receiver stalls.
// Reset empties both banks, selects bank zero and drops any pending result;
// memory contents are not cleared and need no clearing pass.
module positional_phrase_intersect (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // doc_id[15:0], word_pos[35:16], gap[43:36], zeros
    input  logic [1:0]  s_tuser,   // cmd[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata    // matched[0], match_doc[16:1], match_pos[36:17],
                                   // entry_count[47:37], doc_count[58:48],
                                   // overflow[59], zeros
);
    import ppi_pkg::*;

    item_t             item;
    result_t           res;
    result_t           res_reg;
    logic              res_valid;
    logic              m_tvalid_reg;
    logic              out_free;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic [ADDR_W-1:0] rd_addr;
    logic [WORD_W-1:0] rd_data;

    assign item.cmd      = cmd_t'(s_tuser);
    assign item.doc_id   = s_tdata[DOC_W-1:0];
    assign item.word_pos = s_tdata[DOC_W+POS_W-1:DOC_W];
    assign item.gap      = s_tdata[DOC_W+POS_W+GAP_W-1:DOC_W+POS_W];

    assign out_free = !m_tvalid_reg || m_tready;

    ppi_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (s_tvalid),
        .item       (item),
        .item_ready (s_tready),
        .out_free   (out_free),
        .res_valid  (res_valid),
        .res        (res),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data)
    );

    ppi_mem u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            res_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0000, res_reg};

endmodule

/* tb/phrase_match_checker.sv */
`timescale 1ns / 1ps

// Watches both stream channels of the phrase intersector. Every accepted request
// is run through a behavioral copy of the two-bank entry store, and the result
// it should produce is queued. Every accepted result is compared field by field
// with the oldest queued one.
module phrase_match_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,   // doc_id[15:0], word_pos[35:16], gap[43:36], zeros
    input  logic [1:0]  s_tuser,   // cmd[1:0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,   // matched[0], match_doc[16:1], match_pos[36:17],
                                   // entry_count[47:37], doc_count[58:48],
                                   // overflow[59], zeros
    output int          fail_count,
    output int          pending
);
    import ppi_pkg::*;

    localparam logic [DOC_W:0] NO_DOC = '1;

    logic [DOC_W-1:0] doc_mem [0:MEM_DEPTH-1];
    logic [POS_W-1:0] pos_mem [0:MEM_DEPTH-1];
    logic             bank;
    logic [CNT_W-1:0] cur_cnt;
    logic [CNT_W-1:0] nxt_cnt;
    logic [CNT_W-1:0] scan_ptr;
    logic [CNT_W-1:0] nxt_docs;
    logic [DOC_W:0]   last_doc;

    result_t expected_results[$];

    function automatic bit key_before(input logic [DOC_W-1:0] d1, input logic [POS_W-1:0] p1,
                                      input logic [DOC_W-1:0] d2, input logic [POS_W-1:0] p2);
        return (d1 < d2) || (d1 == d2 && p1 < p2);
    endfunction

    task automatic predict_result(input cmd_t c, input logic [DOC_W-1:0] d,
                                  input logic [POS_W-1:0] p, input logic [GAP_W-1:0] g);
        result_t          r;
        int               cur_base;
        int               nxt_base;
        logic [POS_W-1:0] target;
        r = '0;
        cur_base = bank ? TABLE_ENTRIES : 0;
        nxt_base = bank ? 0 : TABLE_ENTRIES;
        case (c)
            CMD_CLEAR:
            begin
                cur_cnt  = '0;
                nxt_cnt  = '0;
                scan_ptr = '0;
                nxt_docs = '0;
                last_doc = NO_DOC;
            end
            CMD_LOAD:
            begin
                if (cur_cnt < TABLE_ENTRIES)
                begin
                    doc_mem[cur_base + int'(cur_cnt)] = d;
                    pos_mem[cur_base + int'(cur_cnt)] = p;
                    cur_cnt = cur_cnt + 1'b1;
                end
                else
                begin
                    r.overflow = 1'b1;
                end
            end
            CMD_PROBE:
            begin
                // A gap beyond the position cannot point at any stored entry.
                if (p >= g)
                begin
                    target = p - g;
                    while (scan_ptr < cur_cnt &&
                           key_before(doc_mem[cur_base + int'(scan_ptr)],
                                      pos_mem[cur_base + int'(scan_ptr)], d, target))
                        scan_ptr = scan_ptr + 1'b1;
                    if (scan_ptr < cur_cnt &&
                        doc_mem[cur_base + int'(scan_ptr)] == d &&
                        pos_mem[cur_base + int'(scan_ptr)] == target)
                    begin
                        scan_ptr    = scan_ptr + 1'b1;
                        r.matched   = 1'b1;
                        r.match_doc = d;
                        r.match_pos = p;
                        if (nxt_cnt < TABLE_ENTRIES)
                        begin
                            doc_mem[nxt_base + int'(nxt_cnt)] = d;
                            pos_mem[nxt_base + int'(nxt_cnt)] = p;
                            nxt_cnt = nxt_cnt + 1'b1;
                            if (last_doc != {1'b0, d})
                            begin
                                nxt_docs = nxt_docs + 1'b1;
                                last_doc = {1'b0, d};
                            end
                        end
                        else
                        begin
                            r.overflow = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                bank          = ~bank;
                cur_cnt       = nxt_cnt;
                r.entry_count = nxt_cnt;
                r.doc_count   = nxt_docs;
                nxt_cnt       = '0;
                scan_ptr      = '0;
                nxt_docs      = '0;
                last_doc      = NO_DOC;
            end
        endcase
        expected_results.insert(expected_results.size(), r);
    endtask

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got)
        begin
            fail_count++;
            if (fail_count <= 100)
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t got;
        result_t want;
        if (!rst_n)
        begin
            bank       = 1'b0;
            cur_cnt    = '0;
            nxt_cnt    = '0;
            scan_ptr   = '0;
            nxt_docs   = '0;
            last_doc   = NO_DOC;
            fail_count = 0;
            pending    = 0;
            expected_results.delete();
        end
        else
        begin
            if (s_tvalid && s_tready)
                predict_result(cmd_t'(s_tuser), s_tdata[15:0], s_tdata[35:16], s_tdata[43:36]);
            if (m_tvalid && m_tready)
            begin
                got = result_t'(m_tdata[59:0]);
                if (expected_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 100)
                        $display("%0t: result with nothing expected, expected none, actual %h",
                                 $time, m_tdata);
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("matched", 32'(want.matched), 32'(got.matched));
                    check_field("match_doc", 32'(want.match_doc), 32'(got.match_doc));
                    check_field("match_pos", 32'(want.match_pos), 32'(got.match_pos));
                    check_field("entry_count", 32'(want.entry_count), 32'(got.entry_count));
                    check_field("doc_count", 32'(want.doc_count), 32'(got.doc_count));
                    check_field("overflow", 32'(want.overflow), 32'(got.overflow));
                end
            end
            pending = expected_results.size();
        end
    end

endmodule

/* tb/positional_phrase_intersect_tb.sv */
`timescale 1ns / 1ps

module positional_phrase_intersect_tb;

    import ppi_pkg::*;

    localparam int RUN_ITEMS = 1600;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;

    int fail_count;
    int pending;
    int issued = 0;
    bit sender_idles = 1'b1;
    bit quiet = 1'b0;
    bit hold_request = 1'b0;

    // Entries the generator believes the current bank holds, sorted.
    int term_doc[$];
    int term_pos[$];

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    positional_phrase_intersect dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    phrase_match_checker match_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Called at a falling edge; returns at the falling edge after the handshake
    // with the request still offered, so the caller must either issue again at
    // once or lower s_tvalid.
    task automatic issue(input cmd_t c, input int d, input int p, input int g);
        if (sender_idles && !quiet && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= c;
        s_tdata  <= {4'b0000, g[7:0], p[19:0], d[15:0]};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
        issued++;
    endtask

    task automatic issue_noise();
        int   r;
        cmd_t c;
        r = $urandom_range(0, 9);
        c = (r < 5) ? CMD_PROBE : (r < 8) ? CMD_LOAD : (r < 9) ? CMD_CLEAR : CMD_COMMIT;
        issue(c, $urandom_range(0, 16'hFFFF), $urandom_range(0, 20'hFFFFF),
              $urandom_range(0, 255));
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic directed_checks();
        issue(CMD_CLEAR, 16'hFFFF, 20'hFFFFF, 255);
        issue(CMD_LOAD, 0, 0, 0);
        issue(CMD_LOAD, 0, 5, 0);
        issue(CMD_LOAD, 7, 100, 0);
        issue(CMD_LOAD, 16'hFFFF, 20'hFFF00, 255);
        // Gap larger than the position never matches.
        issue(CMD_PROBE, 0, 3, 10);
        issue(CMD_PROBE, 0, 200, 255);
        // A zero gap matches the entry at the same position.
        issue(CMD_PROBE, 0, 0, 0);
        issue(CMD_PROBE, 0, 4, 0);
        // The pointer has already passed this entry, so it is missed.
        issue(CMD_PROBE, 0, 0, 0);
        issue(CMD_PROBE, 0, 6, 1);
        issue(CMD_PROBE, 7, 101, 2);
        // A load after probes lands behind the stored entries.
        issue(CMD_LOAD, 16'hFFFF, 20'hFFFFF, 0);
        issue(CMD_PROBE, 16'hFFFF, 20'hFFFFF, 255);
        issue(CMD_PROBE, 16'hFFFF, 20'hFFFFF, 0);
        issue(CMD_COMMIT, 16'hFFFF, 20'hFFFFF, 255);
        issue(CMD_PROBE, 0, 1, 1);
        issue(CMD_COMMIT, 0, 0, 0);
        issue(CMD_COMMIT, 0, 0, 0);
        issue(CMD_LOAD, 16'h1234, 20'h5, 0);
        issue(CMD_COMMIT, 0, 0, 0);
        issue(CMD_CLEAR, 0, 0, 0);
        drain_results();
    endtask

    // Probes the next term against the current list and commits; the probes that
    // hit become the new list.
    task automatic probe_term();
        int g;
        int np;
        int r;
        int nd[$];
        int ns[$];
        r = $urandom_range(0, 7);
        g = (r == 0) ? 0 : (r == 1) ? 255 : $urandom_range(1, 255);
        foreach (term_doc[i])
        begin
            np = term_pos[i] + g;
            if ($urandom_range(0, 11) == 0)
                issue_noise();
            if ($urandom_range(0, 3) == 0 && np >= 1)
                issue(CMD_PROBE, term_doc[i], np - 1, g);
            if (np <= 20'hFFFFF && $urandom_range(0, 9) < 7)
            begin
                issue(CMD_PROBE, term_doc[i], np, g);
                nd.insert(nd.size(), term_doc[i]);
                ns.insert(ns.size(), np);
                if ($urandom_range(0, 15) == 0)
                    issue(CMD_PROBE, term_doc[i], np, g);
            end
        end
        if ($urandom_range(0, 4) == 0)
            issue(CMD_PROBE, 16'hFFFF, $urandom_range(0, 20'hFFFFF), $urandom_range(0, 255));
        issue(CMD_COMMIT, $urandom_range(0, 16'hFFFF), $urandom_range(0, 20'hFFFFF),
              $urandom_range(0, 255));
        term_doc = nd;
        term_pos = ns;
    endtask

    task automatic phrase_phase();
        int n;
        int d;
        int p;
        int r;
        sender_idles = ($urandom_range(0, 9) < 7);
        issue(CMD_CLEAR, $urandom_range(0, 16'hFFFF), $urandom_range(0, 20'hFFFFF),
              $urandom_range(0, 255));
        term_doc.delete();
        term_pos.delete();
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(41, 120) : $urandom_range(1, 40);
        r = $urandom_range(0, 3);
        d = (r == 0) ? 0 : (r == 1) ? 16'hFFFF - $urandom_range(0, 20) :
            $urandom_range(0, 16'hFFFF);
        r = $urandom_range(0, 3);
        p = (r == 0) ? 0 : (r == 1) ? 20'hFFFFF - $urandom_range(0, 300) :
            $urandom_range(0, 20'hFFFFF);
        for (int i = 0; i < n; i++)
        begin
            if (d > 16'hFFFF || p > 20'hFFFFF)
                break;
            term_doc.insert(term_doc.size(), d);
            term_pos.insert(term_pos.size(), p);
            issue(CMD_LOAD, d, p, $urandom_range(0, 255));
            if ($urandom_range(0, 15) == 0)
                issue_noise();
            if ($urandom_range(0, 3) == 0)
            begin
                d += $urandom_range(1, 2000);
                p = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 20'hFFFFF) :
                    $urandom_range(0, 1000);
            end
            else
            begin
                p += $urandom_range(1, 40);
            end
        end
        repeat ($urandom_range(1, 3))
            probe_term();
        if ($urandom_range(0, 3) == 0)
            drain_results();
    endtask

    // Loads past the capacity of one bank, then probes sparsely across it so that
    // single probes scan long stretches of stored entries.
    task automatic fill_table();
        int base;
        int k;
        issue(CMD_CLEAR, 0, 0, 0);
        base = $urandom_range(0, 60000);
        term_doc.delete();
        term_pos.delete();
        for (int i = 0; i < TABLE_ENTRIES + 6; i++)
        begin
            issue(CMD_LOAD, base + i / 16, (i % 16) * 9 + 3, $urandom_range(0, 255));
            if (i < TABLE_ENTRIES)
            begin
                term_doc.insert(term_doc.size(), base + i / 16);
                term_pos.insert(term_pos.size(), (i % 16) * 9 + 3);
            end
        end
        k = 0;
        while (k < TABLE_ENTRIES)
        begin
            issue(CMD_PROBE, term_doc[k], term_pos[k] + 9, 9);
            k += $urandom_range(1, 24);
        end
        issue(CMD_PROBE, term_doc[TABLE_ENTRIES-1], term_pos[TABLE_ENTRIES-1] + 9, 9);
        issue(CMD_COMMIT, 0, 0, 0);
        term_doc.delete();
        term_pos.delete();
    endtask

    initial
    begin : sink
        int tick;
        bit busy;
        tick = 0;
        busy = 1'b1;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            tick++;
            if (tick % 100 == 0)
                busy = ($urandom_range(0, 2) != 0);
            if (hold_request)
            begin
                // Long hold-off so the block fills and stops taking requests.
                m_tready <= 1'b0;
                repeat (300) @(negedge clk);
                hold_request = 1'b0;
                m_tready <= 1'b1;
            end
            else if (!quiet && busy && $urandom_range(0, 7) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge clk);
                m_tready <= 1'b1;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    initial
    begin
        #8_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin : stimulus
        int  phase_no;
        bit  fill_done;
        phase_no  = 0;
        fill_done = 1'b0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        directed_checks();
        while (issued < RUN_ITEMS)
        begin
            if (phase_no == 2)
                hold_request = 1'b1;
            if (!fill_done && issued > 200)
            begin
                fill_table();
                fill_done = 1'b1;
            end
            else
            begin
                phrase_phase();
            end
            phase_no++;
            quiet = (issued > RUN_ITEMS - 250);
        end
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

/* filelist.f */
rtl/ppi_pkg.sv
rtl/ppi_mem.sv
rtl/ppi_engine.sv
rtl/positional_phrase_intersect.sv
tb/phrase_match_checker.sv
tb/positional_phrase_intersect_tb.sv
